// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, token codes and helper functions for the source text
// tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	// Width of the byte position counter
	localparam int POS_BITS = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// Bundles held between scanner and emitter
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	// Token kinds
	localparam logic [5:0] K_LPAREN  = 6'd0;
	localparam logic [5:0] K_RPAREN  = 6'd1;
	localparam logic [5:0] K_LBRACE  = 6'd2;
	localparam logic [5:0] K_RBRACE  = 6'd3;
	localparam logic [5:0] K_COMMA   = 6'd4;
	localparam logic [5:0] K_DOT     = 6'd5;
	localparam logic [5:0] K_SLASH   = 6'd9;
	localparam logic [5:0] K_STAR    = 6'd10;
	localparam logic [5:0] K_BANG    = 6'd12;
	localparam logic [5:0] K_EQUAL   = 6'd14;
	localparam logic [5:0] K_GREATER = 6'd16;
	localparam logic [5:0] K_LESS    = 6'd18;
	localparam logic [5:0] K_IDENT   = 6'd20;
	localparam logic [5:0] K_STRING  = 6'd21;
	localparam logic [5:0] K_NUMBER  = 6'd22;
	localparam logic [5:0] K_INT     = 6'd23;
	localparam logic [5:0] K_CHAR    = 6'd24;
	localparam logic [5:0] K_BYTE    = 6'd25;
	localparam logic [5:0] K_FN      = 6'd29;
	localparam logic [5:0] K_AND     = 6'd33;
	localparam logic [5:0] K_ERROR   = 6'd35;
	localparam logic [5:0] K_EOF     = 6'd36;

	// Error codes
	localparam logic [1:0] E_NONE       = 2'd0;
	localparam logic [1:0] E_UNEXPECTED = 2'd1;
	localparam logic [1:0] E_UNTERM     = 2'd2;

	// Characters of interest
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LESS   = 8'h3C;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	// Keyword prefixes, last byte in the low lane
	localparam logic [31:0] KW_FN   = 32'h0000_666E;
	localparam logic [31:0] KW_AND  = 32'h0061_6E64;
	localparam logic [31:0] KW_INT  = 32'h0069_6E74;
	localparam logic [31:0] KW_BYTE = 32'h6279_7465;
	localparam logic [31:0] KW_CHAR = 32'h6368_6172;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STRING, M_BANG, M_EQUAL,
		M_LESS, M_GREATER, M_SLASH, M_LINECMT, M_BLOCK, M_BLOCKSTAR
	} mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] line;
		logic [15:0] column;
		logic [1:0]  err;
	} token_t;

	// Tokens caused by one item, in order
	typedef struct packed {
		logic [1:0]       count;
		token_t [2:0]     tok;
	} bundle_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Length from start to end, zero if end is behind, saturated
	function automatic logic [15:0] sat_len(input logic [POS_BITS-1:0] e,
			input logic [POS_BITS-1:0] b);
		logic [POS_BITS-1:0] d;
		d = (e >= b) ? e - b : '0;
		return (32'(d) > 32'hFFFF) ? 16'hFFFF : 16'(d);
	endfunction

	function automatic token_t make_tok(input logic [5:0] kind,
			input logic [POS_BITS-1:0] off, input logic [15:0] len,
			input logic [15:0] line, input logic [15:0] col, input logic [1:0] err);
		token_t t;
		t.kind   = kind;
		t.offset = 16'(off);
		t.length = len;
		t.line   = line;
		t.column = col;
		t.err    = err;
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/stt_in_if.sv =====
// ----------------------------------------------------------------------------
// stt_in_if
// Source byte channel: one byte or an end-of-text mark per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source(output valid, output char_code, output end_of_text, input ready);
	modport sink(input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/stt_out_if.sv =====
// ----------------------------------------------------------------------------
// stt_out_if
// Token channel: one token per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [15:0] token_offset;
	logic [15:0] token_length;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic [1:0]  error_kind;
	logic        last_of_run;

	modport source(output valid, output token_kind, output token_offset,
		output token_length, output token_line, output token_column,
		output error_kind, output last_of_run, input ready);
	modport sink(input valid, input token_kind, input token_offset,
		input token_length, input token_line, input token_column,
		input error_kind, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/stt_scan.sv =====
// ----------------------------------------------------------------------------
// stt_scan
// Front end: takes one byte per cycle unless the queue is full, tracks
// position and scan mode, and pushes the tokens each byte completes as one bundle into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      char_code,
	input  wire logic            end_of_text,
	input  wire logic            q_full,
	output logic                 push,
	output stt_pkg::bundle_t     push_data
);
	import stt_pkg::*;

	mode_t               mode_q, mode_n;
	logic [POS_BITS-1:0] pos_q, pos_n, beg_q, beg_n;
	logic [15:0]         line_q, line_n, col_q, col_n;
	logic [15:0]         beg_line_q, beg_line_n, beg_col_q, beg_col_n;
	logic [31:0]         kw_q, kw_n;

	logic                accept;
	logic [POS_BITS-1:0] pos_p1, dot_off;
	logic [15:0]         col_m1, dot_col;
	logic [5:0]          ident_k, op_k;
	token_t              f0, f1, tail;
	logic [1:0]          fcnt, fcnt_eff;
	logic                fall, has_tail;
	bundle_t             b;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Shared values
	always_comb begin
		pos_p1  = (pos_q < POS_MAX) ? pos_q + 1'b1 : POS_MAX;
		dot_off = (pos_q > '0) ? pos_q - 1'b1 : '0;
		col_m1  = (col_q > 16'd0) ? col_q - 16'd1 : 16'd0;
		dot_col = (col_q >= 16'd2) ? col_q - 16'd2 : 16'd0;
		ident_k = K_IDENT;
		if (pos_q - beg_q == POS_BITS'(2) && kw_q == KW_FN) ident_k = K_FN;
		else if (pos_q - beg_q == POS_BITS'(3) && kw_q == KW_AND) ident_k = K_AND;
		else if (pos_q - beg_q == POS_BITS'(3) && kw_q == KW_INT) ident_k = K_INT;
		else if (pos_q - beg_q == POS_BITS'(4) && kw_q == KW_BYTE) ident_k = K_BYTE;
		else if (pos_q - beg_q == POS_BITS'(4) && kw_q == KW_CHAR) ident_k = K_CHAR;
		unique case (mode_q)
			M_BANG:  op_k = K_BANG;
			M_EQUAL: op_k = K_EQUAL;
			M_LESS:  op_k = K_LESS;
			default: op_k = K_GREATER;
		endcase
	end

	// Pending token flushed when the current mode is left
	always_comb begin
		f0   = make_tok(K_NUMBER, beg_q, sat_len(pos_q, beg_q), beg_line_q, beg_col_q, E_NONE);
		f1   = make_tok(K_DOT, dot_off, 16'd1, line_q, dot_col, E_NONE);
		fcnt = 2'd1;
		unique case (mode_q)
			M_IDENT:
				f0.kind = ident_k;
			M_INT, M_FRAC: ;
			M_DOT: begin
				f0.length = sat_len(dot_off, beg_q);
				fcnt = 2'd2;
			end
			M_STRING: begin
				f0.kind = K_ERROR;
				f0.err  = E_UNTERM;
			end
			M_BANG, M_EQUAL, M_LESS, M_GREATER:
				f0.kind = op_k;
			M_SLASH:
				f0.kind = K_SLASH;
			default:
				fcnt = 2'd0;
		endcase
	end

	// Next state and tokens for the accepted item
	always_comb begin
		mode_n     = mode_q;
		pos_n      = pos_q;
		line_n     = line_q;
		col_n      = col_q;
		beg_n      = beg_q;
		beg_line_n = beg_line_q;
		beg_col_n  = beg_col_q;
		kw_n       = kw_q;
		fall       = 1'b0;
		has_tail   = 1'b0;
		tail       = make_tok(K_ERROR, pos_q, sat_len(pos_p1, pos_q), line_q, col_m1,
			E_UNEXPECTED);

		if (end_of_text) begin
			// Flush, then EOF, then back to reset values
			fall     = 1'b1;
			has_tail = 1'b1;
			tail     = make_tok(K_EOF, pos_q, 16'd0, line_q, col_m1, E_NONE);
			mode_n     = M_IDLE;
			pos_n      = '0;
			line_n     = 16'd1;
			col_n      = 16'd1;
			beg_n      = '0;
			beg_line_n = 16'd1;
			beg_col_n  = 16'd0;
			kw_n       = 32'd0;
		end else begin
			unique case (mode_q)
				M_IDLE:
					fall = 1'b1;
				M_IDENT:
					if (is_alpha(char_code) || is_digit(char_code)) begin
						if (pos_q - beg_q < POS_BITS'(4)) kw_n = {kw_q[23:0], char_code};
					end else begin
						fall = 1'b1;
					end
				M_INT:
					if (char_code == CH_DOT) mode_n = M_DOT;
					else if (!is_digit(char_code)) fall = 1'b1;
				M_DOT:
					if (is_digit(char_code)) mode_n = M_FRAC;
					else fall = 1'b1;
				M_FRAC:
					if (!is_digit(char_code)) fall = 1'b1;
				M_STRING:
					if (char_code == CH_QUOTE) begin
						has_tail = 1'b1;
						tail = make_tok(K_STRING, beg_q, sat_len(pos_p1, beg_q),
							beg_line_q, beg_col_q, E_NONE);
						mode_n = M_IDLE;
					end
				M_BANG, M_EQUAL, M_LESS, M_GREATER:
					if (char_code == CH_EQUAL) begin
						has_tail = 1'b1;
						tail = make_tok(op_k + 6'd1, beg_q, sat_len(pos_p1, beg_q),
							beg_line_q, beg_col_q, E_NONE);
						mode_n = M_IDLE;
					end else begin
						fall = 1'b1;
					end
				M_SLASH:
					if (char_code == CH_SLASH) mode_n = M_LINECMT;
					else if (char_code == CH_STAR) mode_n = M_BLOCK;
					else fall = 1'b1;
				M_LINECMT:
					if (char_code == CH_NL) mode_n = M_IDLE;
				M_BLOCK:
					if (char_code == CH_STAR) mode_n = M_BLOCKSTAR;
				M_BLOCKSTAR:
					if (char_code == CH_SLASH) mode_n = M_IDLE;
					else if (char_code != CH_STAR) mode_n = M_BLOCK;
				default:
					fall = 1'b1;
			endcase

			// Byte seen between tokens
			if (fall) begin
				mode_n = M_IDLE;
				if (!(char_code == CH_SPACE || char_code == CH_CR ||
						char_code == CH_TAB || char_code == CH_NL)) begin
					beg_n      = pos_q;
					beg_line_n = line_q;
					beg_col_n  = col_m1;
					if (is_alpha(char_code)) begin
						mode_n = M_IDENT;
						kw_n   = {24'd0, char_code};
					end else if (is_digit(char_code)) begin
						mode_n = M_INT;
					end else begin
						unique case (char_code)
							CH_LPAREN:  begin has_tail = 1'b1; tail.kind = K_LPAREN; end
							CH_RPAREN:  begin has_tail = 1'b1; tail.kind = K_RPAREN; end
							CH_LBRACE:  begin has_tail = 1'b1; tail.kind = K_LBRACE; end
							CH_RBRACE:  begin has_tail = 1'b1; tail.kind = K_RBRACE; end
							CH_COMMA:   begin has_tail = 1'b1; tail.kind = K_COMMA; end
							CH_DOT:     begin has_tail = 1'b1; tail.kind = K_DOT; end
							CH_STAR:    begin has_tail = 1'b1; tail.kind = K_STAR; end
							CH_SLASH:   mode_n = M_SLASH;
							CH_BANG:    mode_n = M_BANG;
							CH_EQUAL:   mode_n = M_EQUAL;
							CH_LESS:    mode_n = M_LESS;
							CH_GREATER: mode_n = M_GREATER;
							CH_QUOTE:   mode_n = M_STRING;
							default:    has_tail = 1'b1;
						endcase
						if (has_tail && tail.kind != K_ERROR) tail.err = E_NONE;
					end
				end
			end

			// Line, column and position counting
			if (char_code == CH_NL) begin
				if (line_q < CNT_MAX) line_n = line_q + 16'd1;
				col_n = 16'd1;
			end else if (col_q < CNT_MAX) begin
				col_n = col_q + 16'd1;
			end
			pos_n = pos_p1;
		end
	end

	// Bundle assembly: flushed tokens first, then the tail token
	always_comb begin
		fcnt_eff = fall ? fcnt : 2'd0;
		b.count  = fcnt_eff + {1'b0, has_tail};
		b.tok[2] = tail;
		b.tok[1] = (fcnt_eff == 2'd2) ? f1 : tail;
		b.tok[0] = (fcnt_eff != 2'd0) ? f0 : tail;
	end

	assign push      = accept && (b.count != 2'd0);
	assign push_data = b;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			pos_q      <= '0;
			line_q     <= 16'd1;
			col_q      <= 16'd1;
			beg_q      <= '0;
			beg_line_q <= 16'd1;
			beg_col_q  <= 16'd0;
			kw_q       <= 32'd0;
		end else if (accept) begin
			mode_q     <= mode_n;
			pos_q      <= pos_n;
			line_q     <= line_n;
			col_q      <= col_n;
			beg_q      <= beg_n;
			beg_line_q <= beg_line_n;
			beg_col_q  <= beg_col_n;
			kw_q       <= kw_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Short FIFO of token bundles between the scanner and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire stt_pkg::bundle_t push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  not_empty,
	output stt_pkg::bundle_t      head
);
	import stt_pkg::*;

	bundle_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign full      = cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stt_emit.sv =====
// ----------------------------------------------------------------------------
// stt_emit
// Back end: walks the head bundle into an output register, one token per cycle
// while that register is empty or being taken, marking the last token of each bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_emit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_not_empty,
	input  wire stt_pkg::bundle_t head,
	output logic                  pop,
	stt_out_if.source             token_out
);
	import stt_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	token_t     tok_q;
	logic       last_q;
	logic       take, is_last;

	assign take    = q_not_empty && (!valid_q || token_out.ready);
	assign is_last = idx_q == head.count - 2'd1;
	assign pop     = take && is_last;

	// Index within the head bundle and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (take) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			if (take) valid_q <= 1'b1;
			else if (token_out.ready) valid_q <= 1'b0;
		end
	end

	// Output token register
	always_ff @(posedge clk) begin
		if (take) begin
			tok_q  <= head.tok[idx_q];
			last_q <= is_last;
		end
	end

	assign token_out.valid        = valid_q;
	assign token_out.token_kind   = tok_q.kind;
	assign token_out.token_offset = tok_q.offset;
	assign token_out.token_length = tok_q.length;
	assign token_out.token_line   = tok_q.line;
	assign token_out.token_column = tok_q.column;
	assign token_out.error_kind   = tok_q.err;
	assign token_out.last_of_run  = last_q;

endmodule

`default_nettype wire

// ===== rtl/source_text_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// The block takes one byte (or an end-of-text mark) every cycle while its
// four-bundle token queue has room. A byte completes zero to three tokens;
// they pass through the queue and leave one per cycle, while the sink is
// ready, from a registered output, with last_of_run set on the final token
// of a byte. Input throughput is therefore one byte per cycle as long as
// tokens average no more than one per byte; the single-token-per-cycle
// output port is what sets the limit otherwise, and input stalls once the
// queue holds four bundles. End of text flushes any pending token, emits
// EOF and returns the scanner to its reset state so that a new text may follow.
`default_nettype none

module source_text_tokenizer_top (
	input  wire logic clk,
	input  wire logic arst_n,
	stt_in_if.sink    text_in,
	stt_out_if.source token_out
);
	import stt_pkg::*;

	logic    q_full, q_not_empty, push, pop;
	bundle_t push_data, head;

	stt_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (text_in.valid),
		.in_ready    (text_in.ready),
		.char_code   (text_in.char_code),
		.end_of_text (text_in.end_of_text),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	stt_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.token_out   (token_out)
	);

	// Error code only on error tokens
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		token_out.valid && token_out.error_kind != E_NONE |-> token_out.token_kind == K_ERROR)
		else $error("error code on a non-error token");

	// EOF is always the last, empty token of its item
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		token_out.valid && token_out.token_kind == K_EOF |->
			token_out.last_of_run && token_out.token_length == 16'd0)
		else $error("malformed EOF token");

	// A bundle is only popped while one is present
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty && head.count != 2'd0)
		else $error("pop of an empty queue");

endmodule

`default_nettype wire

// ===== dv/source_text_tokenizer_top_test.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_test
// Drives source text byte by byte into the tokenizer and checks every token
// against an in-bench scanner model, with random idling on both channels and
// one long hold-off on the token side so that the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_top_test;
	import stt_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} src_item_t;

	typedef struct {
		logic [5:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] line;
		logic [15:0] column;
		logic [1:0]  err;
		logic        last;
	} tok_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stt_in_if  text_in();
	stt_out_if token_out();

	source_text_tokenizer_top dut (
		.clk(clk), .arst_n(arst_n), .text_in(text_in), .token_out(token_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scanner state mirror
	mode_t       sc_mode;
	int unsigned sc_pos, sc_line, sc_col, sc_beg, sc_beg_col, sc_beg_line;
	logic [31:0] sc_prefix;

	src_item_t pending_bytes[$];
	tok_exp_t  expected_tokens[$];
	int        fail_count = 0;
	int        tokens_seen = 0;
	int        bytes_sent = 0;
	bit        all_sent = 1'b0;
	bit        hold_sink = 1'b0;
	bit        quiet = 1'b0;

	function automatic void scanner_reset();
		sc_mode = M_IDLE;
		sc_pos = 0; sc_line = 1; sc_col = 1;
		sc_beg = 0; sc_beg_col = 0; sc_beg_line = 1;
		sc_prefix = '0;
	endfunction

	function automatic void push_tok(logic [5:0] k, int unsigned off, int unsigned len,
			int unsigned ln, int unsigned col, logic [1:0] e);
		tok_exp_t t;
		t.kind = k; t.offset = off[15:0];
		t.length = (len > 65535) ? 16'hFFFF : len[15:0];
		t.line = ln[15:0]; t.column = col[15:0]; t.err = e; t.last = 1'b0;
		expected_tokens.push_back(t);
	endfunction

	function automatic void push_begun(logic [5:0] k, int unsigned e, logic [1:0] er);
		push_tok(k, sc_beg, (e >= sc_beg) ? e - sc_beg : 0, sc_beg_line, sc_beg_col, er);
	endfunction

	function automatic int unsigned pos_next();
		return (sc_pos < 65535) ? sc_pos + 1 : 65535;
	endfunction

	function automatic logic [5:0] word_kind();
		int unsigned n;
		n = sc_pos - sc_beg;
		if (n == 2 && sc_prefix == KW_FN) return K_FN;
		if (n == 3 && sc_prefix == KW_AND) return K_AND;
		if (n == 3 && sc_prefix == KW_INT) return K_INT;
		if (n == 4 && sc_prefix == KW_BYTE) return K_BYTE;
		if (n == 4 && sc_prefix == KW_CHAR) return K_CHAR;
		return K_IDENT;
	endfunction

	function automatic logic [5:0] op_of(mode_t m);
		case (m)
			M_BANG:  return K_BANG;
			M_EQUAL: return K_EQUAL;
			M_LESS:  return K_LESS;
			default: return K_GREATER;
		endcase
	endfunction

	function automatic void number_then_dot();
		int unsigned doff, dcol;
		doff = (sc_pos > 0) ? sc_pos - 1 : 0;
		dcol = (sc_col >= 2) ? sc_col - 2 : 0;
		push_begun(K_NUMBER, doff, E_NONE);
		push_tok(K_DOT, doff, 1, sc_line, dcol, E_NONE);
	endfunction

	function automatic void start_token(logic [7:0] c);
		if (c == CH_SPACE || c == CH_CR || c == CH_TAB || c == CH_NL) return;
		sc_beg = sc_pos; sc_beg_line = sc_line;
		sc_beg_col = (sc_col > 0) ? sc_col - 1 : 0;
		if (is_alpha(c)) begin
			sc_mode = M_IDENT; sc_prefix = {24'd0, c}; return;
		end
		if (is_digit(c)) begin
			sc_mode = M_INT; return;
		end
		case (c)
			CH_LPAREN: push_begun(K_LPAREN, pos_next(), E_NONE);
			CH_RPAREN: push_begun(K_RPAREN, pos_next(), E_NONE);
			CH_LBRACE: push_begun(K_LBRACE, pos_next(), E_NONE);
			CH_RBRACE: push_begun(K_RBRACE, pos_next(), E_NONE);
			CH_COMMA:  push_begun(K_COMMA, pos_next(), E_NONE);
			CH_DOT:    push_begun(K_DOT, pos_next(), E_NONE);
			CH_STAR:   push_begun(K_STAR, pos_next(), E_NONE);
			CH_SLASH:  sc_mode = M_SLASH;
			CH_BANG:   sc_mode = M_BANG;
			CH_EQUAL:  sc_mode = M_EQUAL;
			CH_LESS:   sc_mode = M_LESS;
			CH_GREATER: sc_mode = M_GREATER;
			CH_QUOTE:  sc_mode = M_STRING;
			default:   push_begun(K_ERROR, pos_next(), E_UNEXPECTED);
		endcase
	endfunction

	// Returns 1 when the byte is consumed without falling back to idle
	function automatic bit continue_token(logic [7:0] c);
		mode_t m;
		m = sc_mode;
		case (m)
			M_IDENT: begin
				if (is_alpha(c) || is_digit(c)) begin
					if (sc_pos - sc_beg < 4) sc_prefix = {sc_prefix[23:0], c};
					return 1'b1;
				end
				push_begun(word_kind(), sc_pos, E_NONE);
			end
			M_INT: begin
				if (is_digit(c)) return 1'b1;
				if (c == CH_DOT) begin
					sc_mode = M_DOT; return 1'b1;
				end
				push_begun(K_NUMBER, sc_pos, E_NONE);
			end
			M_DOT: begin
				if (is_digit(c)) begin
					sc_mode = M_FRAC; return 1'b1;
				end
				number_then_dot();
			end
			M_FRAC: begin
				if (is_digit(c)) return 1'b1;
				push_begun(K_NUMBER, sc_pos, E_NONE);
			end
			M_STRING: begin
				if (c == CH_QUOTE) begin
					push_begun(K_STRING, pos_next(), E_NONE);
					sc_mode = M_IDLE;
				end
				return 1'b1;
			end
			M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
				if (c == CH_EQUAL) begin
					push_begun(op_of(m) + 6'd1, pos_next(), E_NONE);
					sc_mode = M_IDLE;
					return 1'b1;
				end
				push_begun(op_of(m), sc_pos, E_NONE);
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					sc_mode = M_LINECMT; return 1'b1;
				end
				if (c == CH_STAR) begin
					sc_mode = M_BLOCK; return 1'b1;
				end
				push_begun(K_SLASH, sc_pos, E_NONE);
			end
			M_LINECMT: begin
				if (c == CH_NL) sc_mode = M_IDLE;
				return 1'b1;
			end
			M_BLOCK: begin
				if (c == CH_STAR) sc_mode = M_BLOCKSTAR;
				return 1'b1;
			end
			M_BLOCKSTAR: begin
				if (c == CH_SLASH) sc_mode = M_IDLE;
				else if (c != CH_STAR) sc_mode = M_BLOCK;
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic void flush_text();
		mode_t m;
		m = sc_mode;
		case (m)
			M_IDENT: push_begun(word_kind(), sc_pos, E_NONE);
			M_INT, M_FRAC: push_begun(K_NUMBER, sc_pos, E_NONE);
			M_DOT: number_then_dot();
			M_STRING: push_begun(K_ERROR, sc_pos, E_UNTERM);
			M_BANG, M_EQUAL, M_LESS, M_GREATER: push_begun(op_of(m), sc_pos, E_NONE);
			M_SLASH: push_begun(K_SLASH, sc_pos, E_NONE);
			default: ;
		endcase
		push_tok(K_EOF, sc_pos, 0, sc_line, (sc_col > 0) ? sc_col - 1 : 0, E_NONE);
	endfunction

	// Predict the tokens caused by one accepted item
	function automatic void predict_tokens(src_item_t it);
		int before_n;
		tok_exp_t t;
		before_n = expected_tokens.size();
		if (it.eot) begin
			flush_text();
			scanner_reset();
		end else begin
			if (!continue_token(it.ch)) begin
				sc_mode = M_IDLE;
				start_token(it.ch);
			end
			if (it.ch == CH_NL) begin
				if (sc_line < 65535) sc_line++;
				sc_col = 1;
			end else if (sc_col < 65535) begin
				sc_col++;
			end
			if (sc_pos < 65535) sc_pos++;
		end
		if (expected_tokens.size() > before_n) begin
			t = expected_tokens.pop_back();
			t.last = 1'b1;
			expected_tokens.push_back(t);
		end
	endfunction

	// Driver: offers queued bytes, idling at random
	initial begin
		text_in.valid = 1'b0;
		text_in.char_code = '0;
		text_in.end_of_text = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && text_in.valid && text_in.ready) begin
			predict_tokens('{ch: text_in.char_code, eot: text_in.end_of_text});
			bytes_sent++;
			void'(pending_bytes.pop_front());
		end
	end

	always @(negedge clk) begin
		if (arst_n && pending_bytes.size() > 0 && (quiet || $urandom_range(99) >= 29)) begin
			text_in.valid <= 1'b1;
			text_in.char_code <= pending_bytes[0].ch;
			text_in.end_of_text <= pending_bytes[0].eot;
		end else begin
			text_in.valid <= 1'b0;
		end
	end

	// Token side: ready with random idling, or held off entirely
	initial token_out.ready = 1'b0;

	always @(negedge clk) begin
		token_out.ready <= arst_n && !hold_sink && (quiet || $urandom_range(99) >= 29);
	end

	// Monitor: compare each token with the oldest expectation
	always @(posedge clk) begin
		tok_exp_t e;
		if (arst_n && token_out.valid && token_out.ready) begin
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				$error("token with nothing expected: kind %0d", token_out.token_kind);
				fail_count++;
			end else begin
				e = expected_tokens.pop_front();
				if (token_out.token_kind !== e.kind) begin
					$error("token_kind exp %0d got %0d", e.kind, token_out.token_kind);
					fail_count++;
				end
				if (token_out.token_offset !== e.offset) begin
					$error("token_offset exp %0d got %0d", e.offset, token_out.token_offset);
					fail_count++;
				end
				if (token_out.token_length !== e.length) begin
					$error("token_length exp %0d got %0d", e.length, token_out.token_length);
					fail_count++;
				end
				if (token_out.token_line !== e.line) begin
					$error("token_line exp %0d got %0d", e.line, token_out.token_line);
					fail_count++;
				end
				if (token_out.token_column !== e.column) begin
					$error("token_column exp %0d got %0d", e.column, token_out.token_column);
					fail_count++;
				end
				if (token_out.error_kind !== e.err) begin
					$error("error_kind exp %0d got %0d", e.err, token_out.error_kind);
					fail_count++;
				end
				if (token_out.last_of_run !== e.last) begin
					$error("last_of_run exp %0d got %0d", e.last, token_out.last_of_run);
					fail_count++;
				end
			end
		end
	end

	task automatic queue_text(string s);
		for (int i = 0; i < s.len(); i++) pending_bytes.push_back('{ch: s[i], eot: 1'b0});
	endtask

	task automatic queue_end();
		pending_bytes.push_back('{ch: 8'($urandom_range(255)), eot: 1'b1});
	endtask

	// Random well-formed lexeme, occasionally noise
	function automatic string random_lexeme();
		string words[] = '{"and", "byte", "char", "fn", "int", "x_1", "Zq", "_", "ch",
			"bytes", "an"};
		string ops[] = '{"(", ")", "{", "}", ",", ".", "*", "/", "!", "!=", "=", "==",
			"<", "<=", ">", ">=", "12.5", "7.", "0", "9876", "\"a b\"", "\"\"",
			"// c\n", "/* x ** */", "\n", "\t", "\r", " ", "3.x"};
		string s;
		case ($urandom_range(9))
			0, 1, 2: s = words[$urandom_range(words.size() - 1)];
			3: begin
				// Any non-zero byte; a string cannot carry a zero byte
				s = " ";
				s.putc(0, 8'($urandom_range(255, 1)));
			end
			default: s = ops[$urandom_range(ops.size() - 1)];
		endcase
		return s;
	endfunction

	// Stimulus
	initial begin
		int n;
		scanner_reset();
		// Directed: every token form, keywords, errors, special cases
		queue_text("(){},.*/ ! != = == < <= > >= and byte char fn int abcd\n");
		queue_end();
		queue_text("12.5 12.a 7 \"s\n\" // c\n/* ** */ + ");
		pending_bytes.push_back('{ch: 8'h00, eot: 1'b0});
		pending_bytes.push_back('{ch: 8'hFF, eot: 1'b0});
		queue_text("#");
		queue_end();
		queue_text("12.");
		queue_end();
		queue_text("\"open");
		queue_end();
		queue_text("/* never");
		queue_end();
		queue_text("/");
		queue_end();
		queue_end();
		// Random texts
		n = 0;
		while (n < 20) begin
			for (int k = $urandom_range(12, 1); k > 0; k--) begin
				string s;
				s = random_lexeme();
				queue_text(s);
				n += s.len();
				if ($urandom_range(1)) queue_text(" ");
			end
			if ($urandom_range(2) == 0) queue_end();
		end
		// Zero and bytes covering every bit, then a tail of dense tokens
		pending_bytes.push_back('{ch: 8'h00, eot: 1'b0});
		for (int b = 0; b < 8; b++) pending_bytes.push_back('{ch: 8'(1 << b), eot: 1'b0});
		queue_end();
		queue_text("(){},.*(){},.*(){},.*(){},.*a=b!c<d>e");
		queue_end();
	end

	// Reset, then one quiet stretch with no idling on either side
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (60) @(posedge clk);
		quiet = 1'b1;
		repeat (60) @(posedge clk);
		quiet = 1'b0;
	end

	// Long hold-off on the token side while bytes are still offered
	initial begin
		wait (arst_n);
		repeat (125) @(posedge clk);
		hold_sink = 1'b1;
		repeat (60) @(posedge clk);
		hold_sink = 1'b0;
	end

	// End of run
	initial begin
		wait (arst_n);
		wait (pending_bytes.size() == 0);
		wait (expected_tokens.size() == 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes and checked %0d tokens, keywords, comments and errors",
			bytes_sent, tokens_seen);
		if (fail_count == 0 && expected_tokens.size() == 0) begin
			$display("source_text_tokenizer_top_test OK");
		end else begin
			$display("source_text_tokenizer_top_test NOT OK");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("source_text_tokenizer_top_test NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/stt_pkg.sv
rtl/stt_in_if.sv
rtl/stt_out_if.sv
rtl/stt_scan.sv
rtl/stt_queue.sv
rtl/stt_emit.sv
rtl/source_text_tokenizer_top.sv
dv/source_text_tokenizer_top_test.sv
